// File: hdl/range_sum_segment_tree_core_macros.svh
// Assertion helpers for the checker file.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef RANGE_SUM_SEGMENT_TREE_CORE_MACROS_SVH
`define RANGE_SUM_SEGMENT_TREE_CORE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define RSST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSST_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RSST_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hdl/rsst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared widths, command codes and request/result types of the range sum
// segment tree core.
// ----------------------------------------------------------------------------
package rsst_pkg;

  localparam int VAL_W = 32;
  localparam int IDX_W = 10;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [IDX_W-1:0]        update_index;
    logic signed [VAL_W-1:0] new_value;
    logic [IDX_W-1:0]        query_low;
    logic [IDX_W-1:0]        query_high;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] range_sum;
    logic                    index_error;
  } res_t;

endpackage

// File: hdl/rsst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rsst_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_seq
// Sequencer of the segment tree: clears the node store after reset, walks
// leaf-to-root for updates and the bottom-up range walk for queries, using a
// single shared 32-bit adder on the RAM read data.
// ----------------------------------------------------------------------------
module rsst_seq #(
  parameter int LEAVES = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_valid_i,
  input  rsst_pkg::req_t                       req_i,
  output logic                                 req_ready_o,
  output logic                                 res_valid_o,
  output rsst_pkg::res_t                       res_o,
  input  logic                                 res_ready_i,
  output logic                                 ram_we_o,
  output logic [$clog2(2*LEAVES)-1:0]          ram_waddr_o,
  output logic [rsst_pkg::VAL_W-1:0]           ram_wdata_o,
  output logic                                 ram_re_o,
  output logic [$clog2(2*LEAVES)-1:0]          ram_raddr_o,
  input  logic [rsst_pkg::VAL_W-1:0]           ram_rdata_i
);

  localparam int NODE_W = $clog2(2*LEAVES);
  localparam int PTR_W  = $clog2(2*LEAVES+1);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(2*LEAVES-1);
  localparam logic [PTR_W-1:0]  LEAF_BASE = PTR_W'(LEAVES);
  localparam logic [PTR_W-1:0]  ONE       = PTR_W'(1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LEAF = 3'd2;
  localparam logic [2:0] S_UP   = 3'd3;
  localparam logic [2:0] S_QL   = 3'd4;
  localparam logic [2:0] S_QR   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]                 state_q, state_d;
  logic [NODE_W-1:0]          clr_q, clr_d;
  logic [PTR_W-1:0]           l_q, l_d;
  logic [PTR_W-1:0]           r_q, r_d;
  logic [rsst_pkg::VAL_W-1:0] acc_q, acc_d;
  logic                       pend_q, pend_d;
  logic                       cmd_q, cmd_d;
  logic                       err_q, err_d;

  logic [rsst_pkg::VAL_W-1:0] sum;
  logic [PTR_W-1:0]           parent;
  logic [PTR_W-1:0]           r_dec;
  logic                       upd_err;
  logic                       qry_err;

  // shared adder: running sum or child sum plus the word just read
  assign sum    = acc_q + ram_rdata_i;
  assign parent = l_q >> 1;
  assign r_dec  = r_q - ONE;

  assign upd_err = 32'(req_i.update_index) >= 32'(LEAVES);
  assign qry_err = (32'(req_i.query_low) >= 32'(LEAVES)) ||
                   (32'(req_i.query_high) >= 32'(LEAVES));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    l_d         = l_q;
    r_d         = r_q;
    acc_d       = acc_q;
    pend_d      = 1'b0;
    cmd_d       = cmd_q;
    err_d       = err_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = l_q[NODE_W-1:0];
    ram_wdata_o = acc_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    case (state_q)
      S_CLR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + NODE_W'(1);
        if (clr_q == LAST_NODE) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_d = req_i.command;
          err_d = 1'b0;
          acc_d = '0;
          if (req_i.command == rsst_pkg::CMD_UPDATE) begin
            if (upd_err) begin
              err_d   = 1'b1;
              state_d = S_FIN;
            end else begin
              l_d     = PTR_W'(req_i.update_index) + LEAF_BASE;
              acc_d   = req_i.new_value;
              state_d = S_LEAF;
            end
          end else begin
            if (qry_err) begin
              err_d   = 1'b1;
              state_d = S_FIN;
            end else if (req_i.query_low > req_i.query_high) begin
              state_d = S_FIN;
            end else begin
              l_d     = PTR_W'(req_i.query_low) + LEAF_BASE;
              r_d     = PTR_W'(req_i.query_high) + LEAF_BASE + ONE;
              state_d = S_QL;
            end
          end
        end
      end
      S_LEAF: begin
        // write the leaf and fetch its sibling
        ram_we_o    = 1'b1;
        ram_re_o    = 1'b1;
        ram_raddr_o = l_q[NODE_W-1:0] ^ NODE_W'(1);
        state_d     = S_UP;
      end
      S_UP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = parent[NODE_W-1:0];
        ram_wdata_o = sum;
        acc_d       = sum;
        l_d         = parent;
        if (parent > ONE) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = parent[NODE_W-1:0] ^ NODE_W'(1);
        end else begin
          state_d = S_FIN;
        end
      end
      S_QL: begin
        if (pend_q) begin
          acc_d = sum;
        end
        if (l_q < r_q) begin
          if (l_q[0]) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = l_q[NODE_W-1:0];
            pend_d      = 1'b1;
            l_d         = l_q + ONE;
          end
          state_d = S_QR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_QR: begin
        if (pend_q) begin
          acc_d = sum;
        end
        if (r_q[0]) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = r_dec[NODE_W-1:0];
          pend_d      = 1'b1;
          r_d         = r_dec >> 1;
        end else begin
          r_d = r_q >> 1;
        end
        l_d     = l_q >> 1;
        state_d = S_QL;
      end
      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_ready_o       = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_FIN);
  assign res_o.range_sum   = (cmd_q == rsst_pkg::CMD_QUERY) ? acc_q : '0;
  assign res_o.index_error = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      cmd_q   <= rsst_pkg::CMD_UPDATE;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      cmd_q   <= cmd_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q   <= l_d;
    r_q   <= r_d;
    acc_q <= acc_d;
  end

endmodule

// File: hdl/range_sum_segment_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_sum_segment_tree_core
// Sum segment tree over LEAVES signed 32-bit elements with point update and
// inclusive range sum query.
// ----------------------------------------------------------------------------
// Requests enter on s_axis; tuser selects update (0) or query (1). Each
// request yields one result on m_axis: the wrapped range sum in tdata (zero
// for updates and errors) and the index error flag in tuser.
// An update takes a leaf write, then a sibling read plus parent write per
// level; a query takes two steps per level on the single RAM read port; an
// empty or out-of-range request goes straight to its result. s_axis_tready is
// high only while the sequencer is idle, so the next request is not taken
// until the sequencer has handed on the previous result.
// After reset the node RAM is cleared with s_axis_tready low. A stalled
// receiver holds the result in the output register; the next request is
// still accepted and its result waits in the sequencer.
// ----------------------------------------------------------------------------
module range_sum_segment_tree_core #(
  parameter int LEAVES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] update_index, [41:10] new_value, [51:42] query_low,
  // [61:52] query_high, [63:62] zero
  input  logic [63:0] s_axis_tdata,
  // [0] command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] range_sum
  output logic [31:0] m_axis_tdata,
  // [0] index_error
  output logic        m_axis_tuser
);

  localparam int NODE_W = $clog2(2*LEAVES);

  rsst_pkg::req_t             req;
  rsst_pkg::res_t             res;
  logic                       res_valid;
  logic                       res_ready;
  logic                       ram_we;
  logic [NODE_W-1:0]          ram_waddr;
  logic [rsst_pkg::VAL_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [NODE_W-1:0]          ram_raddr;
  logic [rsst_pkg::VAL_W-1:0] ram_rdata;

  logic                       out_valid_q, out_valid_d;
  rsst_pkg::res_t             out_res_q;

  assign req.command      = s_axis_tuser;
  assign req.update_index = s_axis_tdata[9:0];
  assign req.new_value    = s_axis_tdata[41:10];
  assign req.query_low    = s_axis_tdata[51:42];
  assign req.query_high   = s_axis_tdata[61:52];

  rsst_seq #(
    .LEAVES(LEAVES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_i      (req),
    .req_ready_o(s_axis_tready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  rsst_ram #(
    .WIDTH(rsst_pkg::VAL_W),
    .DEPTH(2*LEAVES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output register: load when empty or draining this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.range_sum;
  assign m_axis_tuser  = out_res_q.index_error;

endmodule

// File: hdl/rsst_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_chk
// Port-level checker of the range sum segment tree core, bound to the top.
// ----------------------------------------------------------------------------
`include "range_sum_segment_tree_core_macros.svh"

module rsst_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // requests taken whose result is not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `RSST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled result changed")
  `RSST_ASSERT_NEXT(a_one_req, in_acc, !s_axis_tready,
    "request accepted while one is in work")
  `RSST_ASSERT(a_err_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0,
    "index error result with nonzero sum")
  `RSST_ASSERT(a_no_orphan, m_axis_tvalid |-> pend_q != 2'd0,
    "result without a pending request")
  `RSST_ASSERT(a_pend_bound, pend_q != 2'd3,
    "more than two requests outstanding")

endmodule

bind range_sum_segment_tree_core rsst_chk u_rsst_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for range_sum_segment_tree_core. Point updates and range
// sum queries go in on the s_axis side, with a directed table first and random
// traffic after it. A leaf-array shadow predicts results the table does not set;
// the m_axis results are compared in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int   TREE_LEAVES  = 1024;
  localparam int   IDX_W        = rsst_pkg::IDX_W;
  localparam int   VAL_W        = rsst_pkg::VAL_W;
  localparam logic CMD_UPD      = rsst_pkg::CMD_UPDATE;
  localparam logic CMD_QRY      = rsst_pkg::CMD_QUERY;
  localparam int   N_TABLE      = 23;
  localparam int   N_RANDOM     = 1930;
  localparam int   N_CALM       = 200;
  localparam int   PAUSE_AT     = 900;
  // covers the RAM clearing pass after reset plus the longest stalls
  localparam int   QUIET_LIMIT  = 20000;
  localparam int   DRAIN_CYCLES = 40;

  typedef struct {
    logic        cmd;
    logic [9:0]  uidx;
    logic [31:0] val;
    logic [9:0]  lo;
    logic [9:0]  hi;
    bit          typed;
    logic [31:0] sum;
    logic        err;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic signed [VAL_W-1:0] leaf_vals [TREE_LEAVES];
  rsst_pkg::res_t          pending_sums [$];
  table_row_t              dir_rows [N_TABLE];
  int                      errors = 0;
  int                      quiet_cycles = 0;
  bit                      calm = 1'b0;

  range_sum_segment_tree_core #(
    .LEAVES(TREE_LEAVES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the tree kept as plain leaves; a query sums them directly.
  function automatic rsst_pkg::res_t tree_outcome(rsst_pkg::req_t rq);
    rsst_pkg::res_t o;
    logic [31:0]    acc;
    o   = '0;
    acc = '0;
    if (rq.command == CMD_UPD) begin
      if (int'(rq.update_index) >= TREE_LEAVES) o.index_error = 1'b1;
      else leaf_vals[rq.update_index] = rq.new_value;
    end else if (int'(rq.query_low) >= TREE_LEAVES || int'(rq.query_high) >= TREE_LEAVES) begin
      o.index_error = 1'b1;
    end else begin
      // an empty range leaves the loop untouched and the sum at zero
      for (int i = int'(rq.query_low); i <= int'(rq.query_high); i++) acc += leaf_vals[i];
      o.range_sum = acc;
    end
    return o;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return IDX_W'(TREE_LEAVES - 1);
      default: return IDX_W'($urandom_range(0, TREE_LEAVES - 1));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Drive one request and hold it until the core takes it.
  task automatic push_request(rsst_pkg::req_t rq, bit typed, rsst_pkg::res_t want);
    rsst_pkg::res_t model_res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, rq.query_high, rq.query_low, rq.new_value, rq.update_index};
    s_axis_tuser  <= rq.command;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    model_res = tree_outcome(rq);
    pending_sums.push_back(typed ? want : model_res);
    @(posedge clk_i);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain_pause();
    s_axis_tvalid <= 1'b0;
    wait (pending_sums.size() == 0);
    @(posedge clk_i);
  endtask

  initial begin
    rsst_pkg::req_t rq;
    rsst_pkg::res_t want;
    int             span;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_UPD;
    for (int i = 0; i < TREE_LEAVES; i++) leaf_vals[i] = '0;

    dir_rows = '{
      '{CMD_QRY, 10'd0,     32'h0,         10'd0,     10'd1023,  1'b1, 32'h0,         1'b0},
      '{CMD_QRY, 10'h3FF,   32'hFFFF_FFFF, 10'd1023,  10'd1023,  1'b1, 32'h0,         1'b0},
      '{CMD_UPD, 10'd0,     32'h7FFF_FFFF, 10'h3FF,   10'h3FF,   1'b1, 32'h0,         1'b0},
      '{CMD_UPD, 10'd1023,  32'h8000_0000, 10'd0,     10'd0,     1'b1, 32'h0,         1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'd0,     10'd0,     1'b1, 32'h7FFF_FFFF, 1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'd1023,  10'd1023,  1'b1, 32'h8000_0000, 1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'd0,     10'd1023,  1'b1, 32'hFFFF_FFFF, 1'b0},
      '{CMD_UPD, 10'd1,     32'h1,         10'h155,   10'h2AA,   1'b1, 32'h0,         1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'd0,     10'd1,     1'b0, 32'h0,         1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'd5,     10'd4,     1'b1, 32'h0,         1'b0},
      '{CMD_QRY, 10'h2AA,   32'h5555_5555, 10'd1023,  10'd0,     1'b1, 32'h0,         1'b0},
      '{CMD_UPD, 10'd512,   32'hFFFF_FFFF, 10'd7,     10'd3,     1'b1, 32'h0,         1'b0},
      '{CMD_UPD, 10'd511,   32'h1234_5678, 10'd0,     10'd0,     1'b1, 32'h0,         1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'd511,   10'd512,   1'b0, 32'h0,         1'b0},
      '{CMD_QRY, 10'h155,   32'hAAAA_AAAA, 10'd1,     10'd1022,  1'b0, 32'h0,         1'b0},
      '{CMD_UPD, 10'd0,     32'h0,         10'h2AA,   10'h155,   1'b1, 32'h0,         1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'd0,     10'd1023,  1'b0, 32'h0,         1'b0},
      '{CMD_UPD, 10'h2AA,   32'h5555_5555, 10'd0,     10'd0,     1'b1, 32'h0,         1'b0},
      '{CMD_UPD, 10'h155,   32'hAAAA_AAAA, 10'd0,     10'd0,     1'b1, 32'h0,         1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'h155,   10'h2AA,   1'b0, 32'h0,         1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'h2AA,   10'h155,   1'b1, 32'h0,         1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'd0,     10'd511,   1'b0, 32'h0,         1'b0},
      '{CMD_QRY, 10'd0,     32'h0,         10'd512,   10'd1023,  1'b0, 32'h0,         1'b0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) begin
      rq.command          = dir_rows[k].cmd;
      rq.update_index     = dir_rows[k].uidx;
      rq.new_value        = dir_rows[k].val;
      rq.query_low        = dir_rows[k].lo;
      rq.query_high       = dir_rows[k].hi;
      want.range_sum      = dir_rows[k].sum;
      want.index_error    = dir_rows[k].err;
      push_request(rq, dir_rows[k].typed, want);
      sender_gap();
    end
    drain_pause();

    want = '0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == PAUSE_AT) drain_pause();
      calm            = (n >= N_RANDOM - N_CALM);
      rq.command      = $urandom_range(0, 1) ? CMD_QRY : CMD_UPD;
      rq.update_index = pick_index();
      rq.new_value    = pick_value();
      rq.query_low    = pick_index();
      case ($urandom_range(0, 7))
        0: rq.query_high = IDX_W'($urandom_range(0, int'(rq.query_low)));
        1, 2: begin
          span          = int'(rq.query_low) + int'($urandom_range(0, 7));
          rq.query_high = IDX_W'((span > TREE_LEAVES - 1) ? TREE_LEAVES - 1 : span);
        end
        3: rq.query_high = IDX_W'(TREE_LEAVES - 1);
        default: begin
          rq.query_high = pick_index();
          // order the pair so the wide range is non-empty
          if (rq.query_low > rq.query_high) begin
            rq.query_low  = rq.query_low ^ rq.query_high;
            rq.query_high = rq.query_low ^ rq.query_high;
            rq.query_low  = rq.query_low ^ rq.query_high;
          end
        end
      endcase
      push_request(rq, 1'b0, want);
      sender_gap();
    end

    s_axis_tvalid <= 1'b0;
    wait (pending_sums.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: stall in random bursts until the calm tail.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Inputs change only at the rising edge, so the falling edge sees what the
  // next rising edge will accept.
  always @(negedge clk_i) begin : result_check
    rsst_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        $error("result with nothing pending: range_sum %0d", $signed(m_axis_tdata));
        errors++;
      end else begin
        want = pending_sums.pop_front();
        if (m_axis_tdata !== want.range_sum) begin
          $error("range_sum: expected %0d, actual %0d", want.range_sum, $signed(m_axis_tdata));
          errors++;
        end
        if (m_axis_tuser !== want.index_error) begin
          $error("index_error: expected %0b, actual %0b", want.index_error, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: files.f
+incdir+hdl
hdl/rsst_pkg.sv
hdl/rsst_ram.sv
hdl/rsst_seq.sv
hdl/range_sum_segment_tree_core.sv
hdl/rsst_chk.sv
verif/tb_top.sv
